// ===== src/tleh_pkg.sv =====
// ---------------------------------------------------------------------------
// tleh_pkg: shared types and constants
// Key codes, status codes and the result record of the line editor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tleh_pkg;

	localparam int LINE_LEN_DEF      = 64;
	localparam int HISTORY_DEPTH_DEF = 8;

	localparam int POS_W   = 6;
	localparam int BYTE_W  = 8;
	localparam int TDATA_W = 24;

	localparam logic [BYTE_W-1:0] K_ESC     = 8'h1B;
	localparam logic [BYTE_W-1:0] K_BRACKET = 8'h5B;
	localparam logic [BYTE_W-1:0] K_CR      = 8'h0D;
	localparam logic [BYTE_W-1:0] K_LF      = 8'h0A;
	localparam logic [BYTE_W-1:0] K_BS1     = 8'h08;
	localparam logic [BYTE_W-1:0] K_BS2     = 8'h7F;
	localparam logic [BYTE_W-1:0] K_UP      = 8'h41;
	localparam logic [BYTE_W-1:0] K_DOWN    = 8'h42;
	localparam logic [BYTE_W-1:0] K_RIGHT   = 8'h43;
	localparam logic [BYTE_W-1:0] K_LEFT    = 8'h44;
	localparam logic [BYTE_W-1:0] K_NUL     = 8'h00;

	typedef enum logic [1:0] {
		ST_APPLIED   = 2'd0,
		ST_NO_EFFECT = 2'd1,
		ST_FULL      = 2'd2,
		ST_BAD_ESC   = 2'd3
	} status_t;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] line_char;
		logic [POS_W-1:0]  cursor_pos;
		logic [POS_W-1:0]  line_length;
		status_t           status;
		logic              last;
	} res_t;

endpackage

// ===== src/tleh_out_stage.sv =====
// ---------------------------------------------------------------------------
// tleh_out_stage: result holding register
// Holds one result beat for the master side so the sequencer can move on.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tleh_out_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  tleh_pkg::res_t                res,
	output logic                          free,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// line_char[7:0], cursor_pos[13:8], line_length[19:14], status[21:20], zero
	output logic [tleh_pkg::TDATA_W-1:0]  m_tdata,
	// kind
	output logic                          m_tuser,
	output logic                          m_tlast
);

	logic           valid_q;
	tleh_pkg::res_t res_q;

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {2'b00, res_q.status, res_q.line_length, res_q.cursor_pos,
		res_q.line_char};
	assign m_tuser  = res_q.kind;
	assign m_tlast  = res_q.last;

endmodule

// ===== src/terminal_line_editor_history_unit.sv =====
// ---------------------------------------------------------------------------
// terminal_line_editor_history_unit: console line editor with history ring
// Edits one line from console bytes; LF emits the line and files it away.
// ---------------------------------------------------------------------------
// Slave side takes one console byte per beat (s_tdata[7:0]). Every byte gives
// one status beat on the master side (tuser = 0, tlast = 1); LF first gives
// one beat per character of the finished line (tuser = 1, tlast = 0).
// A single sequencer walks the history RAM one column at a time, and the
// block takes no byte until the walk and the status beat load are done.
// Insert and backspace move the bytes behind the cursor; history up/down
// copies or wipes a whole row; LF emits a non-empty line and compares it
// with the previous entry, then wipes the edit row. Other keys only load a
// status beat. After reset a clearing pass writes zero to every RAM entry,
// one a cycle; s_tready stays low meanwhile. A stalled master side holds
// the sequencer at its next beat; one finished beat waits in the output
// register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module terminal_line_editor_history_unit #(
	parameter int LINE_LEN      = tleh_pkg::LINE_LEN_DEF,
	parameter int HISTORY_DEPTH = tleh_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// byte_in[7:0]
	input  logic [tleh_pkg::BYTE_W-1:0]   s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// line_char[7:0], cursor_pos[13:8], line_length[19:14], status[21:20], zero
	output logic [tleh_pkg::TDATA_W-1:0]  m_tdata,
	// kind
	output logic                          m_tuser,
	output logic                          m_tlast
);

	localparam int COL_W     = $clog2(LINE_LEN);
	localparam int SLOT_W    = $clog2(HISTORY_DEPTH);
	localparam int MEM_AW    = SLOT_W + COL_W;
	localparam int MEM_DEPTH = HISTORY_DEPTH * (2 ** COL_W);
	localparam int PW        = tleh_pkg::POS_W;
	localparam int BW        = tleh_pkg::BYTE_W;

	localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(LINE_LEN - 1);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);
	localparam logic [MEM_AW-1:0] ADDR_LAST = MEM_AW'(MEM_DEPTH - 1);
	localparam logic [PW:0]       LEN_CAP   = (PW + 1)'(LINE_LEN);

	typedef enum logic [17:0] {
		S_CLR     = 18'b000000000000000001,
		S_IDLE    = 18'b000000000000000010,
		S_INS_RD  = 18'b000000000000000100,
		S_INS_WR  = 18'b000000000000001000,
		S_INS_PUT = 18'b000000000000010000,
		S_DEL_RD  = 18'b000000000000100000,
		S_DEL_WR  = 18'b000000000001000000,
		S_DEL_Z   = 18'b000000000010000000,
		S_HIS_RD0 = 18'b000000000100000000,
		S_HIS_CHK = 18'b000000001000000000,
		S_HIS_RD  = 18'b000000010000000000,
		S_HIS_WR  = 18'b000000100000000000,
		S_EMIT_RD = 18'b000001000000000000,
		S_EMIT_PT = 18'b000010000000000000,
		S_CMP_RD  = 18'b000100000000000000,
		S_CMP_CHK = 18'b001000000000000000,
		S_WIPE    = 18'b010000000000000000,
		S_STAT    = 18'b100000000000000000
	} state_t;

	state_t              state_q;
	logic [MEM_AW-1:0]   clr_q;
	logic [SLOT_W-1:0]   edit_q, browse_q, nxt_q;
	logic [PW-1:0]       len_q, cur_q, n_q;
	logic [COL_W-1:0]    idx_q;
	logic                found_q;
	logic                esc_q;
	logic [1:0]          esc_cnt_q;
	logic [BW-1:0]       byte_q;
	tleh_pkg::status_t   st_q;

	logic [BW-1:0]       mem [MEM_DEPTH];
	logic [BW-1:0]       rdata_a, rdata_b;
	logic [MEM_AW-1:0]   raddr_a, raddr_b, waddr;
	logic [BW-1:0]       wdata;
	logic                we;

	logic                out_free, out_load;
	tleh_pkg::res_t      out_res;

	logic [SLOT_W-1:0]   edit_up, edit_down, browse_up, browse_down;
	logic [PW:0]         idx_ext, len_ext;
	logic [COL_W-1:0]    idx_m1, idx_p1;
	logic [1:0]          esc_cnt_n;
	logic [PW-1:0]       n_d;
	logic                found_d;
	logic                accept;

	assign edit_up     = (edit_q == '0) ? SLOT_LAST : edit_q - SLOT_W'(1);
	assign edit_down   = (edit_q == SLOT_LAST) ? '0 : edit_q + SLOT_W'(1);
	assign browse_up   = (browse_q == '0) ? SLOT_LAST : browse_q - SLOT_W'(1);
	assign browse_down = (browse_q == SLOT_LAST) ? '0 : browse_q + SLOT_W'(1);
	assign idx_ext     = (PW + 1)'(idx_q);
	assign len_ext     = {1'b0, len_q};
	assign idx_m1      = idx_q - COL_W'(1);
	assign idx_p1      = idx_q + COL_W'(1);
	assign esc_cnt_n   = esc_cnt_q + 2'd1;
	assign accept      = s_tvalid && s_tready;
	assign s_tready    = (state_q == S_IDLE);

	// first zero byte of the copied line sets its length
	always_comb begin
		n_d     = n_q;
		found_d = found_q;
		if (!found_q && (rdata_a == '0 || idx_q == COL_LAST)) begin
			n_d     = PW'(idx_q);
			found_d = 1'b1;
		end
	end

	// RAM ports
	always_comb begin
		raddr_a = {edit_q, idx_q};
		raddr_b = {edit_q, idx_q};
		we      = 1'b0;
		waddr   = {edit_q, idx_q};
		wdata   = '0;
		unique case (state_q)
			S_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			S_INS_RD:  raddr_a = {edit_q, idx_m1};
			S_INS_WR: begin
				we    = 1'b1;
				wdata = rdata_a;
			end
			S_INS_PUT: begin
				we    = 1'b1;
				waddr = {edit_q, cur_q[COL_W-1:0]};
				wdata = byte_q;
			end
			S_DEL_RD:  raddr_a = {edit_q, idx_p1};
			S_DEL_WR: begin
				we    = 1'b1;
				wdata = rdata_a;
			end
			S_DEL_Z: begin
				we    = 1'b1;
				waddr = {edit_q, COL_W'(len_q - PW'(1))};
			end
			S_HIS_RD0: raddr_a = {nxt_q, COL_W'(0)};
			S_HIS_RD:  raddr_a = {nxt_q, idx_q};
			S_HIS_WR: begin
				we    = 1'b1;
				wdata = (idx_q == COL_LAST) ? '0 : rdata_a;
			end
			S_CMP_RD:  raddr_a = {edit_up, idx_q};
			S_WIPE:    we = 1'b1;
			S_IDLE, S_HIS_CHK, S_EMIT_RD, S_EMIT_PT, S_CMP_CHK, S_STAT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

	// result beat
	always_comb begin
		out_load            = 1'b0;
		out_res.kind        = 1'b0;
		out_res.line_char   = '0;
		out_res.cursor_pos  = cur_q;
		out_res.line_length = len_q;
		out_res.status      = st_q;
		out_res.last        = 1'b1;
		if (state_q == S_EMIT_PT) begin
			out_load            = 1'b1;
			out_res.kind        = 1'b1;
			out_res.line_char   = rdata_a;
			out_res.cursor_pos  = '0;
			out_res.line_length = '0;
			out_res.status      = tleh_pkg::ST_APPLIED;
			out_res.last        = 1'b0;
		end else if (state_q == S_STAT) begin
			out_load = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			edit_q    <= '0;
			browse_q  <= '0;
			nxt_q     <= '0;
			len_q     <= '0;
			cur_q     <= '0;
			n_q       <= '0;
			idx_q     <= '0;
			found_q   <= 1'b0;
			esc_q     <= 1'b0;
			esc_cnt_q <= '0;
			byte_q    <= '0;
			st_q      <= tleh_pkg::ST_APPLIED;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + MEM_AW'(1);
					if (clr_q == ADDR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						byte_q  <= s_tdata;
						st_q    <= tleh_pkg::ST_APPLIED;
						state_q <= S_STAT;
						idx_q   <= '0;
						found_q <= 1'b0;
						n_q     <= '0;
						if (esc_q) begin
							if (esc_cnt_n == 2'd1 && s_tdata == tleh_pkg::K_BRACKET) begin
								esc_cnt_q <= esc_cnt_n;
							end else begin
								esc_q     <= 1'b0;
								esc_cnt_q <= '0;
								if (esc_cnt_n != 2'd2) begin
									st_q <= tleh_pkg::ST_BAD_ESC;
								end else begin
									priority case (s_tdata)
										tleh_pkg::K_UP: begin
											nxt_q   <= browse_up;
											state_q <= S_HIS_RD0;
										end
										tleh_pkg::K_DOWN: begin
											nxt_q   <= browse_down;
											state_q <= S_HIS_RD0;
										end
										tleh_pkg::K_RIGHT: begin
											if (cur_q < len_q) cur_q <= cur_q + PW'(1);
											else st_q <= tleh_pkg::ST_NO_EFFECT;
										end
										tleh_pkg::K_LEFT: begin
											if (cur_q != '0) cur_q <= cur_q - PW'(1);
											else st_q <= tleh_pkg::ST_NO_EFFECT;
										end
										default: st_q <= tleh_pkg::ST_BAD_ESC;
									endcase
								end
							end
						end else if (s_tdata == tleh_pkg::K_ESC) begin
							esc_q     <= 1'b1;
							esc_cnt_q <= '0;
						end else if (s_tdata == tleh_pkg::K_CR || s_tdata == tleh_pkg::K_NUL) begin
							st_q <= tleh_pkg::ST_NO_EFFECT;
						end else if (s_tdata == tleh_pkg::K_LF) begin
							state_q <= (len_q == '0) ? S_WIPE : S_EMIT_RD;
						end else if (s_tdata == tleh_pkg::K_BS1 || s_tdata == tleh_pkg::K_BS2) begin
							if (len_q == '0 || cur_q == '0) begin
								st_q <= tleh_pkg::ST_NO_EFFECT;
							end else begin
								cur_q   <= cur_q - PW'(1);
								idx_q   <= COL_W'(cur_q - PW'(1));
								state_q <= (cur_q < len_q) ? S_DEL_RD : S_DEL_Z;
							end
						end else if (len_ext + (PW + 1)'(1) >= LEN_CAP) begin
							st_q <= tleh_pkg::ST_FULL;
						end else if (cur_q == len_q) begin
							state_q <= S_INS_PUT;
						end else begin
							idx_q   <= len_q[COL_W-1:0];
							state_q <= S_INS_RD;
						end
					end
				end
				S_INS_RD:  state_q <= S_INS_WR;
				S_INS_WR: begin
					idx_q   <= idx_m1;
					state_q <= (PW'(idx_m1) == cur_q) ? S_INS_PUT : S_INS_RD;
				end
				S_INS_PUT: begin
					len_q   <= len_q + PW'(1);
					cur_q   <= cur_q + PW'(1);
					state_q <= S_STAT;
				end
				S_DEL_RD:  state_q <= S_DEL_WR;
				S_DEL_WR: begin
					idx_q   <= idx_p1;
					state_q <= (idx_ext + (PW + 1)'(2) < len_ext) ? S_DEL_RD : S_DEL_Z;
				end
				S_DEL_Z: begin
					len_q   <= len_q - PW'(1);
					state_q <= S_STAT;
				end
				S_HIS_RD0: state_q <= S_HIS_CHK;
				S_HIS_CHK: begin
					if (rdata_a == '0) begin
						st_q    <= tleh_pkg::ST_NO_EFFECT;
						state_q <= S_STAT;
					end else begin
						browse_q <= nxt_q;
						state_q  <= (nxt_q == edit_q) ? S_WIPE : S_HIS_RD;
					end
				end
				S_HIS_RD:  state_q <= S_HIS_WR;
				S_HIS_WR: begin
					n_q     <= n_d;
					found_q <= found_d;
					idx_q   <= idx_p1;
					if (idx_q == COL_LAST) begin
						len_q   <= n_d;
						cur_q   <= n_d;
						state_q <= S_STAT;
					end else begin
						state_q <= S_HIS_RD;
					end
				end
				S_EMIT_RD: state_q <= S_EMIT_PT;
				S_EMIT_PT: begin
					if (out_free) begin
						if (idx_ext + (PW + 1)'(1) == len_ext) begin
							idx_q   <= '0;
							state_q <= S_CMP_RD;
						end else begin
							idx_q   <= idx_p1;
							state_q <= S_EMIT_RD;
						end
					end
				end
				S_CMP_RD:  state_q <= S_CMP_CHK;
				S_CMP_CHK: begin
					// line differs from the previous entry: keep it, open a new slot
					if (rdata_a != rdata_b) begin
						edit_q  <= edit_down;
						idx_q   <= '0;
						state_q <= S_WIPE;
					end else if (idx_q == COL_LAST) begin
						idx_q   <= '0;
						state_q <= S_WIPE;
					end else begin
						idx_q   <= idx_p1;
						state_q <= S_CMP_RD;
					end
				end
				S_WIPE: begin
					idx_q <= idx_p1;
					if (idx_q == COL_LAST) begin
						len_q    <= '0;
						cur_q    <= '0;
						browse_q <= edit_q;
						state_q  <= S_STAT;
					end
				end
				S_STAT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	tleh_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (out_load),
		.res      (out_res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	a_cur_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= len_q) else $error("cursor beyond line end");

	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		len_ext < LEN_CAP) else $error("line length overflow");

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready) else $error("byte taken while busy");

	a_slots_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(edit_q <= SLOT_LAST) && (browse_q <= SLOT_LAST))
		else $error("slot index outside ring");

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> !m_tuser) else $error("character beat marked last");

endmodule

// ===== sim/terminal_line_editor_history_unit_test.sv =====
// ---------------------------------------------------------------------------
// terminal_line_editor_history_unit_test: self-checking bench for the editor
// Drives console bytes, predicts every character and status beat in a local
// model of the line and history ring, and compares each output beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module terminal_line_editor_history_unit_test;

	localparam int LL = tleh_pkg::LINE_LEN_DEF;
	localparam int HD = tleh_pkg::HISTORY_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [tleh_pkg::BYTE_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [tleh_pkg::TDATA_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	terminal_line_editor_history_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	// editor state as predicted
	logic [7:0] ring [HD][LL];
	int edit_idx, browse_idx, len_now, cur_now;
	bit esc_on;
	int esc_cnt;

	tleh_pkg::res_t pending_beats[$];
	int errors;
	int send_idle_pct, recv_idle_pct;
	bit hold_off;
	longint cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	function automatic int ring_move(int idx, bit up);
		if (up) return (idx == 0) ? HD - 1 : idx - 1;
		return (idx + 1 >= HD) ? 0 : idx + 1;
	endfunction

	function automatic void queue_beat(bit kind, logic [7:0] ch, tleh_pkg::status_t st,
		bit lst);
		tleh_pkg::res_t r;
		r.kind = kind;
		r.line_char = ch;
		r.cursor_pos = cur_now[5:0];
		r.line_length = len_now[5:0];
		r.status = st;
		r.last = lst;
		pending_beats.push_back(r);
	endfunction

	function automatic tleh_pkg::status_t edit_insert(logic [7:0] b);
		if (len_now + 1 >= LL) return tleh_pkg::ST_FULL;
		for (int i = len_now; i > cur_now; i--) ring[edit_idx][i] = ring[edit_idx][i-1];
		ring[edit_idx][cur_now] = b;
		len_now++;
		cur_now++;
		return tleh_pkg::ST_APPLIED;
	endfunction

	function automatic tleh_pkg::status_t edit_erase();
		if (len_now == 0 || cur_now == 0) return tleh_pkg::ST_NO_EFFECT;
		cur_now--;
		for (int i = cur_now; i + 1 < len_now; i++) ring[edit_idx][i] = ring[edit_idx][i+1];
		len_now--;
		ring[edit_idx][len_now] = 8'h00;
		return tleh_pkg::ST_APPLIED;
	endfunction

	function automatic tleh_pkg::status_t recall(bit up);
		int nxt;
		int n;
		nxt = ring_move(browse_idx, up);
		if (ring[nxt][0] == 8'h00) return tleh_pkg::ST_NO_EFFECT;
		browse_idx = nxt;
		if (nxt != edit_idx) begin
			for (int i = 0; i < LL; i++) ring[edit_idx][i] = ring[nxt][i];
			ring[edit_idx][LL-1] = 8'h00;
		end else begin
			for (int i = 0; i < LL; i++) ring[edit_idx][i] = 8'h00;
		end
		n = 0;
		while (n < LL - 1 && ring[edit_idx][n] != 8'h00) n++;
		len_now = n;
		cur_now = n;
		return tleh_pkg::ST_APPLIED;
	endfunction

	function automatic tleh_pkg::status_t arrow_key(logic [7:0] b);
		case (b)
			tleh_pkg::K_UP: return recall(1'b1);
			tleh_pkg::K_DOWN: return recall(1'b0);
			tleh_pkg::K_RIGHT: begin
				if (cur_now < len_now) begin
					cur_now++;
					return tleh_pkg::ST_APPLIED;
				end
				return tleh_pkg::ST_NO_EFFECT;
			end
			tleh_pkg::K_LEFT: begin
				if (cur_now > 0) begin
					cur_now--;
					return tleh_pkg::ST_APPLIED;
				end
				return tleh_pkg::ST_NO_EFFECT;
			end
			default: return tleh_pkg::ST_BAD_ESC;
		endcase
	endfunction

	function automatic void predict_byte(logic [7:0] b);
		tleh_pkg::status_t st;
		logic [7:0] line_copy [LL];
		int n;
		int prv;
		bit same;
		if (esc_on) begin
			esc_cnt = (esc_cnt + 1) & 3;
			if (esc_cnt == 1 && b == tleh_pkg::K_BRACKET) begin
				st = tleh_pkg::ST_APPLIED;
			end else begin
				st = (esc_cnt == 2) ? arrow_key(b) : tleh_pkg::ST_BAD_ESC;
				esc_on = 1'b0;
				esc_cnt = 0;
			end
		end else if (b == tleh_pkg::K_ESC) begin
			esc_on = 1'b1;
			esc_cnt = 0;
			st = tleh_pkg::ST_APPLIED;
		end else if (b == tleh_pkg::K_CR || b == tleh_pkg::K_NUL) begin
			st = tleh_pkg::ST_NO_EFFECT;
		end else if (b == tleh_pkg::K_LF) begin
			n = len_now;
			for (int i = 0; i < LL; i++) line_copy[i] = ring[edit_idx][i];
			prv = ring_move(edit_idx, 1'b1);
			same = 1'b1;
			for (int i = 0; i < LL; i++)
				if (ring[prv][i] != ring[edit_idx][i]) same = 1'b0;
			if (len_now > 0 && !same) edit_idx = ring_move(edit_idx, 1'b0);
			for (int i = 0; i < LL; i++) ring[edit_idx][i] = 8'h00;
			cur_now = 0;
			len_now = 0;
			browse_idx = edit_idx;
			for (int i = 0; i < n && i < LL - 1; i++)
				queue_beat(1'b1, line_copy[i], tleh_pkg::ST_APPLIED, 1'b0);
			st = tleh_pkg::ST_APPLIED;
		end else if (b == tleh_pkg::K_BS1 || b == tleh_pkg::K_BS2) begin
			st = edit_erase();
		end else begin
			st = edit_insert(b);
		end
		queue_beat(1'b0, 8'h00, st, 1'b1);
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// output checker, with its own random back-pressure
	initial begin
		tleh_pkg::res_t want;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (pending_beats.size() == 0) begin
					report_mismatch("unexpected beat", m_tdata, 0);
				end else begin
					want = pending_beats.pop_front();
					if (m_tuser !== want.kind) report_mismatch("kind", m_tuser, want.kind);
					if (m_tdata[7:0] !== want.line_char)
						report_mismatch("line_char", m_tdata[7:0], want.line_char);
					if (m_tdata[13:8] !== want.cursor_pos)
						report_mismatch("cursor_pos", m_tdata[13:8], want.cursor_pos);
					if (m_tdata[19:14] !== want.line_length)
						report_mismatch("line_length", m_tdata[19:14], want.line_length);
					if (m_tdata[21:20] !== want.status)
						report_mismatch("status", m_tdata[21:20], want.status);
					if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
				end
			end
			m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// tvalid stays up after the accepting edge until the next byte or drain
	task automatic send_byte(logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		predict_byte(b);
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	task automatic send_arrow(logic [7:0] k);
		send_byte(tleh_pkg::K_ESC);
		send_byte(tleh_pkg::K_BRACKET);
		send_byte(k);
	endtask

	task automatic test_directed();
		send_byte(tleh_pkg::K_NUL);
		send_byte(tleh_pkg::K_CR);
		send_byte(tleh_pkg::K_BS1);
		send_arrow(tleh_pkg::K_LEFT);
		send_arrow(tleh_pkg::K_UP);
		send_text("ab");
		send_byte(8'hFF);
		send_byte(8'h01);
		send_arrow(tleh_pkg::K_LEFT);
		send_arrow(tleh_pkg::K_LEFT);
		send_byte(tleh_pkg::K_BS2);
		send_arrow(tleh_pkg::K_RIGHT);
		send_arrow(tleh_pkg::K_RIGHT);
		send_arrow(tleh_pkg::K_RIGHT);
		send_byte(tleh_pkg::K_LF);
		send_byte(tleh_pkg::K_LF);
		send_byte(tleh_pkg::K_ESC);
		send_byte(8'h41);
		send_byte(tleh_pkg::K_ESC);
		send_byte(tleh_pkg::K_BRACKET);
		send_byte(8'h5A);
		send_arrow(tleh_pkg::K_UP);
		send_arrow(tleh_pkg::K_DOWN);
		send_byte(tleh_pkg::K_LF);
		drain();
	endtask

	// fill the line to overflow, then recall the long line
	task automatic test_full_line();
		for (int i = 0; i < LL + 1; i++) send_byte(8'h20 + i);
		send_byte(tleh_pkg::K_LF);
		send_arrow(tleh_pkg::K_UP);
		send_byte(tleh_pkg::K_LF);
		drain();
	endtask

	task automatic test_stall();
		hold_off = 1'b1;
		fork
			begin
				repeat (3000) @(posedge clk);
				hold_off = 1'b0;
			end
			send_text("stall test with the receiver holding off ok");
		join
		send_byte(tleh_pkg::K_LF);
		drain();
	endtask

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 8'($urandom_range(8'h20, 8'h7E));
		if (r < 62) return 8'($urandom_range(255));
		if (r < 70) return tleh_pkg::K_BS2;
		if (r < 74) return tleh_pkg::K_BS1;
		if (r < 78) return tleh_pkg::K_CR;
		if (r < 80) return tleh_pkg::K_NUL;
		return tleh_pkg::K_ESC;
	endfunction

	task automatic test_random(int count);
		int sent;
		int r;
		logic [7:0] b;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(99);
			if (r < 12) begin
				send_byte(tleh_pkg::K_LF);
				sent++;
			end else if (r < 32) begin
				case ($urandom_range(3))
					0: send_arrow(tleh_pkg::K_UP);
					1: send_arrow(tleh_pkg::K_DOWN);
					2: send_arrow(tleh_pkg::K_LEFT);
					default: send_arrow(tleh_pkg::K_RIGHT);
				endcase
				sent += 3;
			end else if (r < 36) begin
				send_byte(tleh_pkg::K_ESC);
				send_byte($urandom_range(1) ? tleh_pkg::K_BRACKET : 8'($urandom_range(255)));
				send_byte(8'($urandom_range(255)));
				sent += 3;
			end else begin
				b = pick_byte();
				if (b != tleh_pkg::K_ESC) begin
					send_byte(b);
					sent++;
				end
			end
		end
		send_byte(tleh_pkg::K_LF);
		drain();
	endtask

	initial begin
		errors = 0;
		hold_off = 1'b0;
		send_idle_pct = 16;
		recv_idle_pct = 86;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		arst_n = 1'b0;
		for (int s = 0; s < HD; s++)
			for (int i = 0; i < LL; i++) ring[s][i] = 8'h00;
		edit_idx = 0;
		browse_idx = 0;
		len_now = 0;
		cur_now = 0;
		esc_on = 1'b0;
		esc_cnt = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_full_line();
		test_stall();
		test_random(100);
		send_idle_pct = 86;
		recv_idle_pct = 16;
		test_random(100);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(100);

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
src/tleh_pkg.sv
src/tleh_out_stage.sv
src/terminal_line_editor_history_unit.sv
sim/terminal_line_editor_history_unit_test.sv
